// File: rtl/decimal_text_to_exif_rational_top_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef DECIMAL_TEXT_TO_EXIF_RATIONAL_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_EXIF_RATIONAL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/dtr_pkg.sv
// Types and constants of the decimal text to rational converter.
`timescale 1ns / 1ps
package dtr_pkg;

  localparam int CHAR_W    = 16;
  localparam int SCALE_W   = 20;
  localparam int SCALE_IW  = $clog2(SCALE_W);
  localparam int ACC_W     = 64;
  localparam int NUM_W     = 32;
  localparam int ALU_W     = ACC_W + 1;
  localparam int ITER_W    = $clog2(ACC_W);

  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_POINT = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_PARSE,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL5,
    ALU_SHADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_W5,
    S_W2,
    S_F5,
    S_F2,
    S_D5,
    S_D2,
    S_MWHOLE,
    S_MFRAC,
    S_ADDH,
    S_DIV,
    S_SUM,
    S_DONE
  } state_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sel;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } in_beat_t;

  typedef struct packed {
    logic [NUM_W-1:0]   numerator;
    logic [SCALE_W-1:0] denominator;
  } out_beat_t;

endpackage

// File: rtl/dtr_stream_if.sv
// Valid/ready stream interface carrying one beat of a given payload type.
`timescale 1ns / 1ps
interface dtr_stream_if #(
  parameter type beat_t = logic
) ();
  logic  valid;
  logic  ready;
  beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/dtr_alu.sv
// Shared 65-bit add/subtract unit with operand shaping for times-5 and shift-add.
`timescale 1ns / 1ps
module dtr_alu (
  input  dtr_pkg::alu_req_t req_i,
  output dtr_pkg::alu_rsp_t rsp_o
);
  import dtr_pkg::*;

  localparam int EXT_W = ALU_W + 1;

  logic [EXT_W-1:0] a_ext;
  logic [EXT_W-1:0] b_ext;
  logic             cin;
  logic [EXT_W-1:0] sum_ext;

  always_comb begin
    a_ext = {1'b0, req_i.a};
    b_ext = {1'b0, req_i.b};
    cin   = 1'b0;
    case (req_i.op)
      ALU_ADD: begin
      end
      ALU_MUL5: begin
        a_ext = {1'b0, req_i.a[ALU_W-3:0], 2'b00};
        b_ext = {1'b0, req_i.a};
      end
      ALU_SHADD: begin
        a_ext = {1'b0, req_i.a[ALU_W-2:0], 1'b0};
        b_ext = req_i.sel ? {1'b0, req_i.b} : '0;
      end
      ALU_SUB: begin
        b_ext = ~{1'b0, req_i.b};
        cin   = 1'b1;
      end
      default: begin
      end
    endcase
    sum_ext = a_ext + b_ext + {{(EXT_W-1){1'b0}}, cin};
  end

  assign rsp_o.sum    = sum_ext[ALU_W-1:0];
  assign rsp_o.borrow = sum_ext[ALU_W];

endmodule

// File: rtl/dtr_ctrl.sv
// Sequencer and accumulators: parses characters, then scales and divides.
`timescale 1ns / 1ps
module dtr_ctrl #(
  parameter int MAX_CHARS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  dtr_pkg::in_beat_t          in_beat_i,
  output logic                       in_ready_o,
  input  logic [dtr_pkg::SCALE_W-1:0] scale_i,
  input  logic                       res_ready_i,
  output logic                       res_valid_o,
  output logic [dtr_pkg::NUM_W-1:0]  res_num_o,
  output dtr_pkg::alu_req_t          alu_req_o,
  input  dtr_pkg::alu_rsp_t          alu_rsp_i
);
  import dtr_pkg::*;

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic               point_q, point_d;
  logic [ACC_W-1:0]   whole_q, whole_d;
  logic [ACC_W-1:0]   frac_q, frac_d;
  logic [ACC_W-1:0]   div_q, div_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ACC_W-1:0]   prod_q, prod_d;
  logic [ACC_W-1:0]   quo_q, quo_d;
  logic [ACC_W-1:0]   rem_q, rem_d;
  logic [3:0]         digit_q, digit_d;
  logic               last_q, last_d;
  logic [ITER_W-1:0]  iter_q, iter_d;

  logic is_digit;
  logic is_blank;
  logic has_frac;

  assign is_digit = in_beat_i.char_code inside {[CH_ZERO:CH_NINE]};
  assign is_blank = in_beat_i.char_code inside {CH_SPACE, CH_TAB};
  assign has_frac = point_q && (div_q != {{(ACC_W-1){1'b0}}, 1'b1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_SKIP;
      point_q <= 1'b0;
      whole_q <= '0;
      frac_q  <= '0;
      div_q   <= {{(ACC_W-1){1'b0}}, 1'b1};
      count_q <= '0;
      last_q  <= 1'b0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      point_q <= point_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      div_q   <= div_d;
      count_q <= count_d;
      last_q  <= last_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    digit_q <= digit_d;
  end

  always_comb begin
    phase_e ph;
    logic   go_w;
    logic   go_f;
    logic   start_final;
    logic   done_digit;
    logic [ALU_W-1:0] shifted;

    state_d = state_q;
    phase_d = phase_q;
    point_d = point_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    div_d   = div_q;
    count_d = count_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    digit_d = digit_q;
    last_d  = last_q;
    iter_d  = iter_q;

    ph          = phase_q;
    go_w        = 1'b0;
    go_f        = 1'b0;
    start_final = 1'b0;
    done_digit  = 1'b0;
    shifted     = {rem_q, quo_q[ACC_W-1]};

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    alu_req_o   = '{op: ALU_ADD, a: '0, b: '0, sel: 1'b0};

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d  = in_beat_i.is_last;
          digit_d = in_beat_i.char_code[3:0];
          if (count_q < CNT_W'(MAX_CHARS)) begin
            count_d = count_q + CNT_W'(1);
            if (ph == PH_SKIP && !is_blank) begin
              ph = PH_PARSE;
            end
            if (ph == PH_PARSE) begin
              if (is_digit) begin
                go_w = !point_q;
                go_f = point_q;
              end else if (in_beat_i.char_code == CH_POINT) begin
                point_d = 1'b1;
              end else begin
                ph = PH_DONE;
              end
            end
            phase_d = ph;
          end
          if (go_w) begin
            state_d = S_W5;
          end else if (go_f) begin
            state_d = S_F5;
          end else if (in_beat_i.is_last) begin
            start_final = 1'b1;
          end
        end
      end
      // times ten as (x*5)*2, digit folded in around the doubling
      S_W5: begin
        alu_req_o = '{op: ALU_MUL5, a: {1'b0, whole_q}, b: '0, sel: 1'b0};
        whole_d   = alu_rsp_i.sum[ACC_W-1:0];
        state_d   = S_W2;
      end
      S_W2: begin
        alu_req_o  = '{op: ALU_ADD, a: {1'b0, whole_q},
                       b: {{(ALU_W-3){1'b0}}, digit_q[3:1]}, sel: 1'b0};
        whole_d    = {alu_rsp_i.sum[ACC_W-2:0], digit_q[0]};
        done_digit = 1'b1;
      end
      S_F5: begin
        alu_req_o = '{op: ALU_MUL5, a: {1'b0, frac_q}, b: '0, sel: 1'b0};
        frac_d    = alu_rsp_i.sum[ACC_W-1:0];
        state_d   = S_F2;
      end
      S_F2: begin
        alu_req_o = '{op: ALU_ADD, a: {1'b0, frac_q},
                      b: {{(ALU_W-3){1'b0}}, digit_q[3:1]}, sel: 1'b0};
        frac_d    = {alu_rsp_i.sum[ACC_W-2:0], digit_q[0]};
        state_d   = S_D5;
      end
      S_D5: begin
        alu_req_o = '{op: ALU_MUL5, a: {1'b0, div_q}, b: '0, sel: 1'b0};
        div_d     = alu_rsp_i.sum[ACC_W-1:0];
        state_d   = S_D2;
      end
      S_D2: begin
        alu_req_o  = '{op: ALU_ADD, a: {1'b0, div_q}, b: '0, sel: 1'b0};
        div_d      = {alu_rsp_i.sum[ACC_W-2:0], 1'b0};
        done_digit = 1'b1;
      end
      // whole * scale, MSB-first shift-add
      S_MWHOLE: begin
        alu_req_o = '{op: ALU_SHADD, a: {1'b0, prod_q}, b: {1'b0, whole_q},
                      sel: scale_i[iter_q[SCALE_IW-1:0]]};
        prod_d    = alu_rsp_i.sum[ACC_W-1:0];
        if (iter_q == '0) begin
          quo_d = '0;
          if (has_frac) begin
            iter_d  = ITER_W'(SCALE_W - 1);
            state_d = S_MFRAC;
          end else begin
            state_d = S_SUM;
          end
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      S_MFRAC: begin
        alu_req_o = '{op: ALU_SHADD, a: {1'b0, quo_q}, b: {1'b0, frac_q},
                      sel: scale_i[iter_q[SCALE_IW-1:0]]};
        quo_d     = alu_rsp_i.sum[ACC_W-1:0];
        if (iter_q == '0) begin
          state_d = S_ADDH;
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      // add half the divisor for rounding
      S_ADDH: begin
        alu_req_o = '{op: ALU_ADD, a: {1'b0, quo_q},
                      b: {2'b00, div_q[ACC_W-1:1]}, sel: 1'b0};
        quo_d     = alu_rsp_i.sum[ACC_W-1:0];
        rem_d     = '0;
        iter_d    = ITER_W'(ACC_W - 1);
        state_d   = S_DIV;
      end
      // restoring division, dividend shifts out of quo_q as quotient shifts in
      S_DIV: begin
        alu_req_o = '{op: ALU_SUB, a: shifted, b: {1'b0, div_q}, sel: 1'b0};
        if (alu_rsp_i.borrow) begin
          rem_d = shifted[ACC_W-1:0];
        end else begin
          rem_d = alu_rsp_i.sum[ACC_W-1:0];
        end
        quo_d = {quo_q[ACC_W-2:0], !alu_rsp_i.borrow};
        if (iter_q == '0) begin
          state_d = S_SUM;
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      S_SUM: begin
        alu_req_o = '{op: ALU_ADD, a: {1'b0, prod_q}, b: {1'b0, quo_q}, sel: 1'b0};
        prod_d    = alu_rsp_i.sum[ACC_W-1:0];
        state_d   = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          phase_d = PH_SKIP;
          point_d = 1'b0;
          whole_d = '0;
          frac_d  = '0;
          div_d   = {{(ACC_W-1){1'b0}}, 1'b1};
          count_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_digit) begin
      if (last_q) begin
        start_final = 1'b1;
      end else begin
        state_d = S_IDLE;
      end
    end
    if (start_final) begin
      prod_d  = '0;
      iter_d  = ITER_W'(SCALE_W - 1);
      state_d = S_MWHOLE;
    end
  end

  assign res_num_o = prod_q[NUM_W-1:0];

endmodule

// File: rtl/decimal_text_to_exif_rational_top.sv
// Top level of the decimal text to fixed-point rational converter.
//
// Usage: text enters on in_i, one UTF-16 character per beat, with is_last
// set on the final character of a string. Leading blanks are skipped, digits
// build the whole and fraction parts, and the first other character but a
// point ends parsing. On the last beat one result beat leaves on out_o:
// numerator is the rounded value times scale (low 32 bits), denominator is
// the scale. Only write scale via cfg_we_i/cfg_wdata_i when idle; unchecked.
//
// Flow: in_i.ready is high only while the sequencer is idle. A beat with a
// whole-part digit takes two passes on the whole accumulator, a fraction
// digit two passes each on its accumulator and the divisor, before the next
// beat is taken. After the last beat the shared adder runs 20 shift-add
// steps for the whole part; with a fraction it runs 20 more, one rounding
// add and 64 restoring division steps. One final add follows, and then the
// sequencer offers the result to the output register that drives out_o.
//
// Reset clears the parse state and sets scale to 1; there is no clearing
// pass. If the receiver stalls, the result waits in the output register and
// the sequencer holds its own result until the register frees up.
`timescale 1ns / 1ps
`include "decimal_text_to_exif_rational_top_defines.svh"
module decimal_text_to_exif_rational_top #(
  parameter int MAX_CHARS = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dtr_pkg::SCALE_W-1:0] cfg_wdata_i,
  dtr_stream_if.sink                  in_i,
  dtr_stream_if.source                out_o
);
  import dtr_pkg::*;

  // scale register, doubles as the denominator
  logic [SCALE_W-1:0] scale_q;

  // output register
  logic               out_valid_q;
  logic [NUM_W-1:0]   out_num_q;
  logic [SCALE_W-1:0] out_den_q;

  logic               in_ready;
  logic               res_valid;
  logic               res_ready;
  logic [NUM_W-1:0]   res_num;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1);
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  dtr_ctrl #(
    .MAX_CHARS (MAX_CHARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_beat_i   (in_i.payload),
    .in_ready_o  (in_ready),
    .scale_i     (scale_q),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_num_o   (res_num),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp)
  );

  dtr_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_i.ready = in_ready;

  // load when empty or draining this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_num_q <= res_num;
      out_den_q <= scale_q;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.payload.numerator   = out_num_q;
  assign out_o.payload.denominator = out_den_q;

  // the sequencer never offers a result while it takes characters
  `DTR_ASSERT(a_idle_no_result, in_ready, !res_valid)
  // a last beat always starts the scaling pass
  `DTR_ASSERT_NEXT(a_last_busy, in_i.valid && in_ready && in_i.payload.is_last, !in_ready)
  // the output register only fills from a sequencer result
  `DTR_ASSERT(a_out_from_result, $rose(out_valid_q), $past(res_valid))

endmodule
